// ===== rtl/frtt_pkg.sv =====
// Shared constants, widths and types for the fan ramp transition time unit.
// Used by every module in the rtl folder; it depends on nothing else.
`default_nettype none

package frtt_pkg;

	// Fraction bits of a curve power value.
	localparam int FRAC_BITS = 16;
	localparam int PW        = FRAC_BITS + 1;
	// Spin-up product widths: difference times spin-up time, then times 1000.
	localparam int PROD_W    = PW + 16;
	localparam int NUM_W     = PROD_W + 10;

	// Internal log/exp format has 30 fraction bits.
	localparam int QB        = 30;
	localparam logic [29:0] LN2_Q = 30'd744261118;
	// floor(2^34 / 25), used to form q * 2^30 / 100.
	localparam logic [29:0] DIV100_RECIP = 30'd687194767;

	// Cell counts of the three chains.
	localparam int N_SQ  = 30;
	localparam int N_TAY = 14;
	localparam int N_DIV = 30;

	// Reciprocals ceil(2^34 / k) for the series term division by k.
	localparam logic [34:0] TWO34 = 35'h4_0000_0000;
	localparam logic [34:0] TAY_RECIP [1:14] = '{
		TWO34,
		(TWO34 + 35'd1) / 35'd2,
		(TWO34 + 35'd2) / 35'd3,
		(TWO34 + 35'd3) / 35'd4,
		(TWO34 + 35'd4) / 35'd5,
		(TWO34 + 35'd5) / 35'd6,
		(TWO34 + 35'd6) / 35'd7,
		(TWO34 + 35'd7) / 35'd8,
		(TWO34 + 35'd8) / 35'd9,
		(TWO34 + 35'd9) / 35'd10,
		(TWO34 + 35'd10) / 35'd11,
		(TWO34 + 35'd11) / 35'd12,
		(TWO34 + 35'd12) / 35'd13,
		(TWO34 + 35'd13) / 35'd14
	};

	// Configuration register indexes.
	localparam logic [1:0] REG_SPIN_UP  = 2'd0;
	localparam logic [1:0] REG_EXPONENT = 2'd1;
	localparam logic [1:0] REG_COAST    = 2'd2;

	// Per-request control that travels beside the datapath.
	typedef struct packed {
		logic valid;
		logic spin;
		logic coast;
	} ctrl_t;

	// Total pipeline depth from acceptance to the output register.
	localparam int DEPTH = 68;

endpackage

`default_nettype wire

// ===== rtl/frtt_sq_cell.sv =====
// One squaring step of the base-2 logarithm: yields one fraction bit.
// Depends on frtt_pkg.
`default_nettype none

module frtt_sq_cell import frtt_pkg::*; (
	input  logic        clk,
	input  logic [30:0] v_in,
	input  logic [29:0] frac_in,
	output logic [30:0] v_out,
	output logic [29:0] frac_out
);

	logic [61:0] sq;
	logic [31:0] w;

	// Square the mantissa and renormalize into [1,2).
	always_comb begin
		sq = 62'(v_in) * 62'(v_in);
		w  = sq[61:QB];
	end

	always_ff @(posedge clk) begin
		if (w[31]) begin
			v_out <= w[31:1];
		end else begin
			v_out <= w[30:0];
		end
		frac_out <= {frac_in[28:0], w[31]};
	end

endmodule

`default_nettype wire

// ===== rtl/frtt_tay_cell.sv =====
// One term of the exponential series, two stages: multiply, then divide by k.
// Depends on frtt_pkg for the reciprocal table.
`default_nettype none

module frtt_tay_cell import frtt_pkg::*; (
	input  logic        clk,
	input  logic [3:0]  k,
	input  logic [29:0] z_in,
	input  logic [30:0] t_in,
	input  logic [31:0] sum_in,
	output logic [29:0] z_out,
	output logic [30:0] t_out,
	output logic [31:0] sum_out
);

	logic [60:0] tz;
	logic [29:0] w_s1;
	logic [29:0] z_s1;
	logic [31:0] sum_s1;
	logic [64:0] qprod;
	logic [30:0] t_new;

	// First stage: previous term times z.
	always_comb begin
		tz = 61'(t_in) * 61'(z_in);
	end

	always_ff @(posedge clk) begin
		w_s1   <= tz[59:QB];
		z_s1   <= z_in;
		sum_s1 <= sum_in;
	end

	// Second stage: exact division by k through its reciprocal.
	always_comb begin
		qprod = 65'(w_s1) * 65'(TAY_RECIP[k]);
		t_new = qprod[64:34];
	end

	always_ff @(posedge clk) begin
		z_out   <= z_s1;
		t_out   <= t_new;
		sum_out <= sum_s1 + 32'(t_new);
	end

endmodule

`default_nettype wire

// ===== rtl/frtt_div_cell.sv =====
// One restoring division step: produces one quotient bit.
// Depends on frtt_pkg.
`default_nettype none

module frtt_div_cell import frtt_pkg::*; (
	input  logic        clk,
	input  logic [17:0] den_in,
	input  logic [17:0] rem_in,
	input  logic [29:0] nlo_in,
	input  logic [29:0] quot_in,
	output logic [17:0] den_out,
	output logic [17:0] rem_out,
	output logic [29:0] nlo_out,
	output logic [29:0] quot_out
);

	logic [18:0] r2;
	logic        ge;

	// Bring down the next numerator bit and try a subtraction.
	always_comb begin
		r2 = {rem_in, nlo_in[29]};
		ge = (r2 >= 19'(den_in));
	end

	always_ff @(posedge clk) begin
		den_out  <= den_in;
		nlo_out  <= {nlo_in[28:0], 1'b0};
		quot_out <= {quot_in[28:0], ge};
		if (ge) begin
			rem_out <= 18'(r2 - 19'(den_in));
		end else begin
			rem_out <= r2[17:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/frtt_power.sv =====
// Curve power ((q)/100)^e through a log2 chain and an exp2 series chain.
// Depends on frtt_pkg, frtt_sq_cell and frtt_tay_cell.
`default_nettype none

module frtt_power import frtt_pkg::*; (
	input  logic          clk,
	input  logic [6:0]    q,
	input  logic [15:0]   exponent,
	output logic [PW-1:0] pw
);

	logic [30:0] est_s1;
	logic [6:0]  q_s1;
	logic [35:0] r_s2;
	logic [30:0] v_s2;
	logic [30:0] vn_s3;
	logic [2:0]  n_s3;
	logic [2:0]  n_sel;
	logic [62:0] qz_sr;
	logic [2:0]  n_sr [0:N_SQ-1];
	logic [30:0] sq_v [0:N_SQ];
	logic [29:0] sq_f [0:N_SQ];
	logic [32:0] l_val;
	logic [48:0] yprod;
	logic [34:0] y_s34;
	logic [60:0] zprod;
	logic [29:0] z_s35;
	logic [4:0]  k_s35;
	logic [4:0]  k_sr [0:2*N_TAY-1];
	logic [29:0] tz [0:N_TAY];
	logic [30:0] tt [0:N_TAY];
	logic [31:0] ts [0:N_TAY];
	logic [6:0]  sh;
	logic [40:0] rsum;
	logic [40:0] shifted;

	// q * 2^30 / 100 estimate by reciprocal; low by at most one.
	always_ff @(posedge clk) begin
		est_s1 <= 31'((37'(q) * 37'(DIV100_RECIP)) >> 6);
		q_s1   <= q;
	end

	// Correct the estimate with one compare.
	always_comb begin
		r_s2 = {1'b0, q_s1, 28'b0} - (36'(est_s1) * 36'd25);
	end

	always_ff @(posedge clk) begin
		if (r_s2 >= 36'd25) begin
			v_s2 <= est_s1 + 31'd1;
		end else begin
			v_s2 <= est_s1;
		end
	end

	// Normalize into [1,2): count leading zeros over eight positions.
	always_comb begin
		n_sel = 3'd7;
		for (int i = 7; i >= 0; i--) begin
			if (v_s2[30-i]) begin
				n_sel = 3'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		vn_s3 <= v_s2 << n_sel;
		n_s3  <= n_sel;
	end

	// Zero-base flag rides beside the whole chain.
	always_ff @(posedge clk) begin
		qz_sr <= {qz_sr[61:0], (q == 7'd0)};
	end

	// Squaring chain for the fraction bits of the logarithm.
	assign sq_v[0] = vn_s3;
	assign sq_f[0] = '0;

	for (genvar i = 0; i < N_SQ; i++) begin : g_sq
		frtt_sq_cell u_sq (
			.clk      (clk),
			.v_in     (sq_v[i]),
			.frac_in  (sq_f[i]),
			.v_out    (sq_v[i+1]),
			.frac_out (sq_f[i+1])
		);
	end

	always_ff @(posedge clk) begin
		n_sr[0] <= n_s3;
		for (int i = 1; i < N_SQ; i++) begin
			n_sr[i] <= n_sr[i-1];
		end
	end

	// Scale the negative logarithm by the exponent.
	always_comb begin
		l_val = {n_sr[N_SQ-1], 30'b0} - {3'b0, sq_f[N_SQ]};
		yprod = 49'(exponent) * 49'(l_val);
	end

	always_ff @(posedge clk) begin
		y_s34 <= yprod[48:14];
	end

	// Series argument (1 - f) * ln2.
	always_comb begin
		zprod = 61'(31'h4000_0000 - 31'(y_s34[29:0])) * 61'(LN2_Q);
	end

	always_ff @(posedge clk) begin
		z_s35 <= zprod[59:QB];
		k_s35 <= y_s34[34:30];
	end

	// Exponential series chain.
	assign tz[0] = z_s35;
	assign tt[0] = 31'h4000_0000;
	assign ts[0] = 32'h4000_0000;

	for (genvar i = 0; i < N_TAY; i++) begin : g_tay
		frtt_tay_cell u_tay (
			.clk     (clk),
			.k       (4'(i + 1)),
			.z_in    (tz[i]),
			.t_in    (tt[i]),
			.sum_in  (ts[i]),
			.z_out   (tz[i+1]),
			.t_out   (tt[i+1]),
			.sum_out (ts[i+1])
		);
	end

	always_ff @(posedge clk) begin
		k_sr[0] <= k_s35;
		for (int i = 1; i < 2*N_TAY; i++) begin
			k_sr[i] <= k_sr[i-1];
		end
	end

	// Final shift by the integer part, with rounding and special cases.
	always_comb begin
		sh      = 7'(k_sr[2*N_TAY-1]) + 7'(31 - FRAC_BITS);
		rsum    = 41'(ts[N_TAY]) + (41'd1 << (sh - 7'd1));
		shifted = rsum >> sh;
	end

	always_ff @(posedge clk) begin
		if (exponent == 16'd0) begin
			pw <= PW'(1) << FRAC_BITS;
		end else if (qz_sr[62] || (sh > 7'd40)) begin
			pw <= '0;
		end else begin
			pw <= shifted[PW-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fan_ramp_transition_time_unit.sv =====
// Fan ramp transition time unit: top level.
// One request is accepted every cycle; busy stays low and the output cannot stall.
// The depth is set by the 30 log2 squaring cells and 14 two-stage series cells.
// Reset clears all request valids and loads the register defaults.
// Depends on frtt_pkg, frtt_power and frtt_div_cell.
`default_nettype none

module fan_ramp_transition_time_unit import frtt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  start_percent,
	input  logic [7:0]  end_percent,
	output logic        done,
	output logic [29:0] time_us,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] spin_up_q;
	logic [15:0] exponent_q;
	logic [15:0] coast_q;

	logic [6:0]  sat1;
	logic [6:0]  sat2;
	logic [6:0]  p1_s1;
	logic [6:0]  p2_s1;
	ctrl_t       ctrl_sr [0:DEPTH-2];
	logic [6:0]  a_sr [0:34];
	logic [6:0]  b_sr [0:34];

	logic [PW-1:0]     pw1;
	logic [PW-1:0]     pw2;
	logic [PW-1:0]     dpw;
	logic [PROD_W-1:0] prod_s66;
	logic [NUM_W-1:0]  num_spin;
	logic [29:0]       spin_res_s67;

	logic [16:0] td;
	logic [33:0] numa_s36;
	logic [6:0]  diff_s36;
	logic [13:0] ab_s36;
	logic [17:0] den;
	logic [41:0] num_s37;
	logic [17:0] den_s37;
	logic [17:0] dd [0:N_DIV];
	logic [17:0] dr [0:N_DIV];
	logic [29:0] dn [0:N_DIV];
	logic [29:0] dq [0:N_DIV];

	logic        done_q;
	logic [29:0] time_q;

	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_up_q  <= 16'd0;
			exponent_q <= 16'd8192;
			coast_q    <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPIN_UP:  spin_up_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				REG_COAST:    coast_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate the percentages.
	always_comb begin
		sat1 = (start_percent > 8'd100) ? 7'd100 : start_percent[6:0];
		sat2 = (end_percent > 8'd100) ? 7'd100 : end_percent[6:0];
	end

	// Control line: valid and mode for every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH-1; i++) begin
				ctrl_sr[i] <= '0;
			end
		end else begin
			ctrl_sr[0].valid <= start && !busy;
			ctrl_sr[0].spin  <= (spin_up_q != 16'd0) && (sat2 > sat1);
			ctrl_sr[0].coast <= (spin_up_q != 16'd0) && (sat2 < sat1);
			for (int i = 1; i < DEPTH-1; i++) begin
				ctrl_sr[i] <= ctrl_sr[i-1];
			end
		end
	end

	// Request payload and coast-down operand delay line.
	always_ff @(posedge clk) begin
		p1_s1   <= sat1;
		p2_s1   <= sat2;
		a_sr[0] <= (sat1 == 7'd0) ? 7'd1 : sat1;
		b_sr[0] <= (sat2 == 7'd0) ? 7'd1 : sat2;
		for (int i = 1; i < 35; i++) begin
			a_sr[i] <= a_sr[i-1];
			b_sr[i] <= b_sr[i-1];
		end
	end

	// Spin-up powers for both percentages.
	frtt_power u_pow1 (
		.clk      (clk),
		.q        (7'd100 - p1_s1),
		.exponent (exponent_q),
		.pw       (pw1)
	);

	frtt_power u_pow2 (
		.clk      (clk),
		.q        (7'd100 - p2_s1),
		.exponent (exponent_q),
		.pw       (pw2)
	);

	// Spin-up time: power difference times the spin-up time.
	always_comb begin
		dpw = (pw1 > pw2) ? (pw1 - pw2) : '0;
	end

	always_ff @(posedge clk) begin
		prod_s66 <= PROD_W'(dpw) * PROD_W'(spin_up_q);
	end

	always_comb begin
		num_spin = NUM_W'(prod_s66) * NUM_W'(1000) + (NUM_W'(1) << (FRAC_BITS - 1));
	end

	always_ff @(posedge clk) begin
		spin_res_s67 <= 30'(num_spin >> FRAC_BITS);
	end

	// Coast-down numerator and denominator.
	always_comb begin
		td  = (coast_q != 16'd0) ? 17'(coast_q) : {spin_up_q, 1'b0};
		den = 18'(ab_s36) * 18'd19;
	end

	always_ff @(posedge clk) begin
		numa_s36 <= 34'(td) * 34'd100000;
		diff_s36 <= a_sr[34] - b_sr[34];
		ab_s36   <= 14'(a_sr[34]) * 14'(b_sr[34]);
		num_s37  <= 42'(numa_s36) * 42'(diff_s36) + 42'(den >> 1);
		den_s37  <= den;
	end

	// Coast-down divider chain, one quotient bit per cell.
	assign dd[0] = den_s37;
	assign dr[0] = 18'(num_s37[41:30]);
	assign dn[0] = num_s37[29:0];
	assign dq[0] = '0;

	for (genvar i = 0; i < N_DIV; i++) begin : g_div
		frtt_div_cell u_div (
			.clk      (clk),
			.den_in   (dd[i]),
			.rem_in   (dr[i]),
			.nlo_in   (dn[i]),
			.quot_in  (dq[i]),
			.den_out  (dd[i+1]),
			.rem_out  (dr[i+1]),
			.nlo_out  (dn[i+1]),
			.quot_out (dq[i+1])
		);
	end

	// Output register: select by mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_sr[DEPTH-2].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_sr[DEPTH-2].spin) begin
			time_q <= spin_res_s67;
		end else if (ctrl_sr[DEPTH-2].coast) begin
			time_q <= dq[N_DIV];
		end else begin
			time_q <= '0;
		end
	end

	assign done    = done_q;
	assign time_us = time_q;

	// Every accepted request gives a result after the full depth.
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##68 done)
		else $error("request did not produce a result");

	// A result only appears for a request accepted the full depth earlier.
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 68))
		else $error("result without a request");

	// Disabled or equal percentages give zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_sr[DEPTH-2].valid && !ctrl_sr[DEPTH-2].spin && !ctrl_sr[DEPTH-2].coast)
		|=> (time_us == 30'd0))
		else $error("idle mode gave nonzero time");

	// Spin-up and coast-down never apply together.
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_sr[0].spin && ctrl_sr[0].coast))
		else $error("both modes set");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the fan ramp transition time unit.
// Drives requests and register writes, predicts each time in SystemVerilog; needs frtt_pkg and
// the RTL.
`default_nettype none

class ramp_time_board;
	longint unsigned spin_ms;
	longint unsigned curve_e;
	longint unsigned coast_ms;
	logic [29:0] pending_times[$];
	int errors;

	function new();
		spin_ms = 0;
		curve_e = 8192;
		coast_ms = 0;
		errors = 0;
	endfunction

	// -log2(q/100) with 30 fraction bits, q in 1..100.
	function longint unsigned neg_log2(longint unsigned q);
		longint unsigned v;
		longint unsigned n;
		longint unsigned frac;
		v = (q << 30) / 100;
		n = 0;
		frac = 0;
		while (v < (64'd1 << 30)) begin
			v = v << 1;
			n++;
		end
		for (int i = 0; i < 30; i++) begin
			v = (v * v) >> 30;
			frac = frac << 1;
			if (v >= (64'd1 << 31)) begin
				v = v >> 1;
				frac = frac | 1;
			end
		end
		return (n << 30) - frac;
	endfunction

	// 2^(1-f) by a truncated Taylor series of exp.
	function longint unsigned exp2_rest(longint unsigned f);
		longint unsigned z;
		longint unsigned sum;
		longint unsigned t;
		z = (((64'd1 << 30) - f) * 64'd744261118) >> 30;
		sum = 64'd1 << 30;
		t = sum;
		for (int k = 1; k <= 14; k++) begin
			t = ((t * z) >> 30) / k;
			sum += t;
		end
		return sum;
	endfunction

	// ((100-p)/100)^e with 16 fraction bits, given q = 100 - p.
	function longint unsigned power_of(longint unsigned q);
		longint unsigned y;
		longint unsigned s;
		if (curve_e == 0)
			return 64'd1 << frtt_pkg::FRAC_BITS;
		if (q == 0)
			return 0;
		y = (curve_e * neg_log2(q)) >> 14;
		s = (y >> 30) + 1 + 30 - frtt_pkg::FRAC_BITS;
		if (s > 40)
			return 0;
		return (exp2_rest(y & ((64'd1 << 30) - 1)) + (64'd1 << (s - 1))) >> s;
	endfunction

	function void write_reg(logic [1:0] idx, logic [15:0] value);
		case (idx)
			frtt_pkg::REG_SPIN_UP: begin
				spin_ms = value;
			end
			frtt_pkg::REG_EXPONENT: begin
				curve_e = value;
			end
			frtt_pkg::REG_COAST: begin
				coast_ms = value;
			end
			default: begin
			end
		endcase
	endfunction

	// Note an accepted request and queue its predicted time.
	function void note_request(logic [7:0] sp, logic [7:0] ep);
		longint unsigned p1;
		longint unsigned p2;
		longint unsigned t;
		longint unsigned t1;
		longint unsigned t2;
		longint unsigned td;
		longint unsigned a;
		longint unsigned b;
		longint unsigned den;
		p1 = (sp > 100) ? 100 : sp;
		p2 = (ep > 100) ? 100 : ep;
		t = 0;
		if (spin_ms != 0 && p1 != p2) begin
			if (p2 > p1) begin
				t1 = power_of(100 - p1);
				t2 = power_of(100 - p2);
				if (t1 > t2)
					t = ((t1 - t2) * spin_ms * 1000 + (64'd1 << (frtt_pkg::FRAC_BITS - 1)))
						>> frtt_pkg::FRAC_BITS;
			end else begin
				td = (coast_ms != 0) ? coast_ms : 2 * spin_ms;
				a = (p1 < 1) ? 1 : p1;
				b = (p2 < 1) ? 1 : p2;
				if (a > b) begin
					den = 19 * a * b;
					t = (100000 * td * (a - b) + den / 2) / den;
				end
			end
		end
		pending_times.push_back(t[29:0]);
	endfunction

	// Compare one result with the oldest predicted time.
	function void check_time(logic [29:0] actual);
		logic [29:0] want;
		if (pending_times.size() == 0) begin
			$display("%0t: unexpected result time_us=%0d", $time, actual);
			errors++;
			return;
		end
		want = pending_times.pop_front();
		if (want !== actual) begin
			$display("%0t: time_us expected %0d actual %0d", $time, want, actual);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import frtt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [7:0] start_percent = '0;
	logic [7:0] end_percent = '0;
	logic done;
	logic [29:0] time_us;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	longint unsigned cycle_count = 0;
	ramp_time_board board = new();

	fan_ramp_transition_time_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_percent(start_percent), .end_percent(end_percent),
		.done(done), .time_us(time_us),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every strobed result and guard the run length.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_time(time_us);
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Send one request and hold it until accepted.
	task automatic send_request(logic [7:0] sp, logic [7:0] ep);
		start <= 1'b1;
		start_percent <= sp;
		end_percent <= ep;
		do @(posedge clk); while (busy);
		board.note_request(sp, ep);
	endtask

	task automatic drop_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Random gap: mostly none or short, sometimes long.
	task automatic random_gap();
		int n;
		n = 0;
		if ($urandom_range(0, 3) == 0)
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Wait for every pending result, then for the pipeline to drain.
	task automatic drain();
		start <= 1'b0;
		while (board.pending_times.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
	endtask

	// One register write; the enable drops again before the next write.
	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.write_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_percent();
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(101, 255));
			1: return 8'(0);
			2: return 8'(100);
			default: return 8'($urandom_range(0, 100));
		endcase
	endfunction

	initial begin
		logic [15:0] spin_set [6];
		logic [15:0] exp_set [6];
		logic [15:0] coast_set [6];
		spin_set = '{16'd1000, 16'd65535, 16'd1, 16'd3000, 16'd0, 16'd500};
		exp_set = '{16'd8192, 16'd65535, 16'd0, 16'd16384, 16'd1, 16'd24576};
		coast_set = '{16'd0, 16'd65535, 16'd2000, 16'd0, 16'd1, 16'd7};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: the block is disabled, every time is zero.
		send_request(8'd0, 8'd100);
		send_request(8'd100, 8'd0);
		drop_start();
		drain();

		// Directed pass: extremes, saturation, equal duties, both directions.
		write_reg(REG_SPIN_UP, 16'd65535);
		write_reg(REG_EXPONENT, 16'd16384);
		write_reg(REG_COAST, 16'd0);
		send_request(8'd0, 8'd100);
		send_request(8'd100, 8'd0);
		send_request(8'd255, 8'd0);
		send_request(8'd0, 8'd255);
		send_request(8'd50, 8'd50);
		send_request(8'd200, 8'd101);
		send_request(8'd1, 8'd0);
		send_request(8'd0, 8'd1);
		send_request(8'd99, 8'd100);
		send_request(8'd100, 8'd5);
		send_request(8'd170, 8'd85);
		send_request(8'd85, 8'd170);
		drop_start();
		drain();
		write_reg(REG_EXPONENT, 16'd0);
		write_reg(REG_COAST, 16'd65535);
		send_request(8'd0, 8'd100);
		send_request(8'd30, 8'd70);
		send_request(8'd100, 8'd1);
		send_request(8'd0, 8'd0);
		drop_start();
		drain();
		write_reg(REG_EXPONENT, 16'd65535);
		send_request(8'd0, 8'd99);
		send_request(8'd0, 8'd100);
		send_request(8'd10, 8'd20);
		drop_start();
		drain();

		// Random phases over several register settings.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_SPIN_UP, spin_set[ph]);
			write_reg(REG_EXPONENT, exp_set[ph]);
			write_reg(REG_COAST, coast_set[ph]);
			for (int i = 0; i < 180; i++) begin
				send_request(pick_percent(), pick_percent());
				if (ph != 3)
					random_gap();
			end
			drop_start();
			drain();
			write_reg(REG_EXPONENT, 16'($urandom));
			write_reg(REG_COAST, 16'($urandom));
			write_reg(REG_SPIN_UP, 16'($urandom));
			for (int i = 0; i < 10; i++) begin
				send_request(8'($urandom), 8'($urandom));
				random_gap();
			end
			drop_start();
			drain();
		end

		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

`default_nettype wire
